FILE: src/eipl4_pkg.sv
// Package for the Ethernet/IPv4/L4 header parser: beat types, status codes
// and the fixed header offsets. No dependencies.
package eipl4_pkg;

  // Fixed header geometry
  localparam logic [6:0]  EthHdrBytes = 7'd14;
  localparam logic [6:0]  IpMinBytes  = 7'd20;
  localparam logic [6:0]  TcpMinBytes = 7'd20;
  localparam logic [6:0]  UdpHdrBytes = 7'd8;
  localparam logic [15:0] EtypeIpv4   = 16'h0800;
  localparam logic [7:0]  ProtoTcp    = 8'd6;
  localparam logic [7:0]  ProtoUdp    = 8'd17;
  localparam logic [3:0]  IpVersion4  = 4'd4;
  localparam int unsigned IdxWidth    = 17;
  localparam logic [IdxWidth-1:0] IdxMax = {IdxWidth{1'b1}};

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_SHORT_ETH   = 4'd1,
    ST_NOT_IPV4    = 4'd2,
    ST_SHORT_IP    = 4'd3,
    ST_BAD_VERSION = 4'd4,
    ST_BAD_IHL     = 4'd5,
    ST_SHORT_TCP   = 4'd6,
    ST_BAD_TCP_OFF = 4'd7,
    ST_SHORT_UDP   = 4'd8
  } status_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       is_last;
  } in_beat_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  protocol;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] ip_total_length;
    logic [5:0]  ip_header_bytes;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] tcp_sequence;
  } out_beat_t;

endpackage

FILE: src/eth_ipv4_l4_header_parser_unit.sv
// Ethernet/IPv4/TCP-UDP header parser, one frame byte per beat.
// Depends on eipl4_pkg for beat types, status codes and header offsets.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------
//  in      | to block  | in_valid_i / in_stall_o | in_data_i  (in_beat_t)
//  out     | from block| out_valid_o/ out_stall_i| out_data_o (out_beat_t)
//
// Takes one byte beat every cycle while no final byte waits on a stalled
// result; a result is registered when the final byte moves from the input
// register into the result register.
// The input side stalls only while a final byte waits on a stalled result.
// Reset clears the byte counter, all captured fields and both valid flags.
// A held result never stops non-final bytes of the next frame from flowing.
module eth_ipv4_l4_header_parser_unit
  import eipl4_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  // Input register
  logic     in_valid_q, in_valid_d;
  in_beat_t in_q;

  // Per-frame capture state
  logic [IdxWidth-1:0] byte_idx_q, byte_idx_d;
  logic [15:0] ether_type_q, ether_type_d;
  logic [7:0]  version_ihl_q, version_ihl_d;
  logic [15:0] total_len_q, total_len_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_addr_q, src_addr_d;
  logic [31:0] dst_addr_q, dst_addr_d;
  logic [15:0] src_port_q, src_port_d;
  logic [15:0] dst_port_q, dst_port_d;
  logic [31:0] seq_q, seq_d;
  logic [3:0]  tcp_off_q, tcp_off_d;

  // Result register
  logic      out_valid_q, out_valid_d;
  out_beat_t out_q, out_d;

  logic                in_accept;
  logic                out_free;
  logic                advance;
  logic                frame_end;
  logic [IdxWidth-1:0] pos;
  logic [IdxWidth-1:0] idx_inc;
  logic [6:0]          l4_off;
  logic [IdxWidth-1:0] rel;
  logic [7:0]          b;
  logic [5:0]          ihl_bytes;
  logic [IdxWidth-1:0] tcp_need;
  logic [IdxWidth-1:0] udp_need;
  logic [IdxWidth-1:0] total_ext;
  status_e             status;

  // Handshake: a non-final byte always advances; a final byte needs room.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (!in_q.is_last || out_free);
  assign frame_end  = advance && in_q.is_last;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign in_valid_d = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);

  // Byte position and L4 offset from the IHL seen so far
  assign pos     = byte_idx_q;
  assign b       = in_q.frame_byte;
  assign idx_inc = (byte_idx_q == IdxMax) ? byte_idx_q : byte_idx_q + 1'b1;
  assign l4_off  = EthHdrBytes + {1'b0, version_ihl_q[3:0], 2'b00};
  assign rel     = pos - {{(IdxWidth-7){1'b0}}, l4_off};

  // Field capture: shift each header byte into its register as it passes.
  always_comb begin
    ether_type_d  = ether_type_q;
    version_ihl_d = version_ihl_q;
    total_len_d   = total_len_q;
    proto_d       = proto_q;
    src_addr_d    = src_addr_q;
    dst_addr_d    = dst_addr_q;
    src_port_d    = src_port_q;
    dst_port_d    = dst_port_q;
    seq_d         = seq_q;
    tcp_off_d     = tcp_off_q;

    priority if (pos == 17'd12 || pos == 17'd13) begin
      ether_type_d = {ether_type_q[7:0], b};
    end else if (pos == 17'd14) begin
      version_ihl_d = b;
    end else if (pos == 17'd16 || pos == 17'd17) begin
      total_len_d = {total_len_q[7:0], b};
    end else if (pos == 17'd23) begin
      proto_d = b;
    end else if (pos >= 17'd26 && pos <= 17'd29) begin
      src_addr_d = {src_addr_q[23:0], b};
    end else if (pos >= 17'd30 && pos <= 17'd33) begin
      dst_addr_d = {dst_addr_q[23:0], b};
    end else begin
      ether_type_d = ether_type_q;
    end

    // L4 fields, relative to the end of the IP header
    if (pos >= {{(IdxWidth-7){1'b0}}, l4_off}) begin
      priority if (rel <= 17'd1) begin
        src_port_d = {src_port_q[7:0], b};
      end else if (rel <= 17'd3) begin
        dst_port_d = {dst_port_q[7:0], b};
      end else if (rel <= 17'd7) begin
        seq_d = {seq_q[23:0], b};
      end else if (rel == 17'd12) begin
        tcp_off_d = b[7:4];
      end else begin
        seq_d = seq_q;
      end
    end
  end

  // Frame checks on the values as they stand after this byte
  assign ihl_bytes = {version_ihl_d[3:0], 2'b00};
  assign tcp_need  = {{(IdxWidth-7){1'b0}},
                      EthHdrBytes + TcpMinBytes + {1'b0, ihl_bytes}};
  assign udp_need  = {{(IdxWidth-7){1'b0}},
                      EthHdrBytes + UdpHdrBytes + {1'b0, ihl_bytes}};
  assign total_ext = {1'b0, total_len_d} + {{(IdxWidth-7){1'b0}}, EthHdrBytes};

  always_comb begin
    priority if (idx_inc < {{(IdxWidth-7){1'b0}}, EthHdrBytes}) begin
      status = ST_SHORT_ETH;
    end else if (ether_type_d != EtypeIpv4) begin
      status = ST_NOT_IPV4;
    end else if (idx_inc < {{(IdxWidth-7){1'b0}}, EthHdrBytes + IpMinBytes}) begin
      status = ST_SHORT_IP;
    end else if (version_ihl_d[7:4] != IpVersion4) begin
      status = ST_BAD_VERSION;
    end else if ({1'b0, ihl_bytes} < IpMinBytes) begin
      status = ST_BAD_IHL;
    end else if (proto_d == ProtoTcp && idx_inc < tcp_need) begin
      status = ST_SHORT_TCP;
    end else if (proto_d == ProtoTcp && {1'b0, tcp_off_d, 2'b00} < TcpMinBytes) begin
      status = ST_BAD_TCP_OFF;
    end else if (proto_d == ProtoUdp && idx_inc < udp_need) begin
      status = ST_SHORT_UDP;
    end else begin
      status = ST_OK;
    end
  end

  // Assemble the result; a failed frame reports only its status.
  always_comb begin
    out_d        = '0;
    out_d.status = status;
    if (status == ST_OK) begin
      out_d.protocol        = proto_d;
      out_d.source_address  = src_addr_d;
      out_d.dest_address    = dst_addr_d;
      // Clamp the length to the bytes actually present after Ethernet
      out_d.ip_total_length = (total_ext > idx_inc)
                              ? 16'(idx_inc - {{(IdxWidth-7){1'b0}}, EthHdrBytes})
                              : total_len_d;
      out_d.ip_header_bytes = ihl_bytes;
      if (proto_d == ProtoTcp || proto_d == ProtoUdp) begin
        out_d.source_port = src_port_d;
        out_d.dest_port   = dst_port_d;
      end
      if (proto_d == ProtoTcp) begin
        out_d.tcp_sequence = seq_d;
      end
    end
  end

  assign out_valid_d = frame_end ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  assign byte_idx_d  = frame_end ? '0 : idx_inc;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
  end

  // Capture state: advance on each byte, clear after the final one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_idx_q    <= '0;
      ether_type_q  <= '0;
      version_ihl_q <= '0;
      total_len_q   <= '0;
      proto_q       <= '0;
      src_addr_q    <= '0;
      dst_addr_q    <= '0;
      src_port_q    <= '0;
      dst_port_q    <= '0;
      seq_q         <= '0;
      tcp_off_q     <= '0;
    end else if (frame_end) begin
      byte_idx_q    <= '0;
      ether_type_q  <= '0;
      version_ihl_q <= '0;
      total_len_q   <= '0;
      proto_q       <= '0;
      src_addr_q    <= '0;
      dst_addr_q    <= '0;
      src_port_q    <= '0;
      dst_port_q    <= '0;
      seq_q         <= '0;
      tcp_off_q     <= '0;
    end else if (advance) begin
      byte_idx_q    <= byte_idx_d;
      ether_type_q  <= ether_type_d;
      version_ihl_q <= version_ihl_d;
      total_len_q   <= total_len_d;
      proto_q       <= proto_d;
      src_addr_q    <= src_addr_d;
      dst_addr_q    <= dst_addr_d;
      src_port_q    <= src_port_d;
      dst_port_q    <= dst_port_d;
      seq_q         <= seq_d;
      tcp_off_q     <= tcp_off_d;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_end) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |->
      out_data_o.protocol == 8'd0 && out_data_o.source_address == 32'd0 &&
      out_data_o.ip_total_length == 16'd0 && out_data_o.tcp_sequence == 32'd0)
    else $error("failed frame carries captured fields");

  a_ports_l4_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.protocol != ProtoTcp && out_data_o.protocol != ProtoUdp
      |-> out_data_o.source_port == 16'd0 && out_data_o.dest_port == 16'd0)
    else $error("ports reported for a non-L4 protocol");

  a_clear_after_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_end |=> byte_idx_q == '0 && proto_q == 8'd0)
    else $error("capture state not cleared after final byte");

  a_last_waits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && in_q.is_last && out_valid_q && out_stall_i |-> in_stall_o && !frame_end)
    else $error("final byte overran a held result");

endmodule
